FILE: rtl/core/cds_pkg.sv
// Shared types, constants and month tables for the calendar date stepper.
// No dependencies; every other file of the block but cds_checker imports this package.
package cds_pkg;

   localparam logic [13:0] MAX_YEAR     = 14'd9999;
   localparam logic [21:0] LAST_SERIAL  = 22'd3652058;
   // serial number of 2000-01-01, the reset date
   localparam logic [21:0] RESET_SERIAL = 22'd730119;

   // floor(p / 100) = (p * 5243) >> 19, exact for p below 43699
   localparam logic [12:0] DIV100_MUL   = 13'd5243;
   localparam int          DIV100_SHIFT = 19;
   // lower bound of s / 366, never above the exact quotient
   localparam logic [11:0] DIV366_MUL   = 12'd2864;
   localparam int          DIV366_SHIFT = 20;

   typedef enum logic [1:0] {
      FUNC_LOAD = 2'd0,
      FUNC_FWD  = 2'd1,
      FUNC_BACK = 2'd2,
      FUNC_DIFF = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ORD_EQUAL   = 2'd0,
      ORD_EARLIER = 2'd1,
      ORD_LATER   = 2'd2
   } ord_type;

   // operand of the shared year unit
   typedef enum logic [1:0] {
      YR_CUR,
      YR_NEXT,
      YR_GIVEN
   } yr_sel_type;

   typedef struct packed {
      logic       capture;
      yr_sel_type yr_sel;
      logic       check;
      logic       resolve;
      logic       step_add;
      logic       estimate;
      logic       y_inc;
      logic       base_sub;
      logic       month_step;
      logic       month_store;
      logic       out_write;
   } dp_cmd_type;

   typedef struct packed {
      func_type func;
      logic     year_at_max;
      logic     next_fits;
      logic     month_more;
      logic     out_free;
   } dp_status_type;

   function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      unique case (month)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] days_before_month(input logic [3:0] month,
                                                     input logic leap);
      logic [8:0] base;
      unique case (month)
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd59;
         4'd4:    base = 9'd90;
         4'd5:    base = 9'd120;
         4'd6:    base = 9'd151;
         4'd7:    base = 9'd181;
         4'd8:    base = 9'd212;
         4'd9:    base = 9'd243;
         4'd10:   base = 9'd273;
         4'd11:   base = 9'd304;
         4'd12:   base = 9'd334;
         default: base = 9'd0;
      endcase
      if (leap && (month > 4'd2)) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage

FILE: rtl/core/calendar_date_stepper.sv
// Top level of the calendar date stepper: sequencer plus datapath.
// Depends on cds_pkg, cds_ctrl, cds_datapath (and cds_year_unit below it).
//
// Usage:
//   The block holds one Gregorian date (0001-01-01 .. 9999-12-31). Each
//   request on the req_ stream carries an operation in req_tuser: load a
//   date, step forward or back by a day count, or compare against a date.
//   Every request yields exactly one response on the rsp_ stream with the
//   stored date after the operation, an error flag in rsp_tuser, and the
//   day difference and order for a compare.
// Timing:
//   One request at a time. Load and compare look up the given year in the
//   year unit, then check the date, resolve it and write the response. Steps
//   add or subtract the count and estimate a start year; the new year is then
//   found by a search that tries each candidate year in the shared two-stage
//   year unit, and the month walk then passes one month per cycle.
// Reset:
//   Synchronous, active high. The stored date returns to 2000-01-01 and the
//   response register empties.
// Backpressure:
//   A finished response waits in the output register; the next request is
//   accepted meanwhile, and only its own result holds until rsp_tready.
module calendar_date_stepper import cds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // day_in[4:0], month_in[8:5], year_in[22:9],
                                   // step_count[38:23], zero pad[39]
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // day_out[4:0], month_out[8:5], year_out[22:9],
                                   // day_difference[44:23], order[46:45], zero[47]
   output logic        rsp_tuser   // error_flag
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequence each request through the datapath
   cds_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // hold the date, do the arithmetic and drive the response register
   cds_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

FILE: rtl/core/cds_year_unit.sv
// Two-stage year unit: days before January 1 of a year, and its leap flag.
// Depends on cds_pkg for the divide-by-100 reciprocal.
module cds_year_unit import cds_pkg::*; (
   input  logic        clock,
   input  logic [13:0] operand,
   output logic [21:0] dby,
   output logic        leap
);

   logic [13:0] p_ff, p_in;
   logic [7:0]  qp_ff, qp_in;
   logic        quad_ff, quad_in;
   logic [21:0] dby_ff, dby_in;
   logic        leap_ff, leap_in;

   logic [26:0] q_prod;
   logic [13:0] rem100;
   logic        century;
   logic [22:0] dby_wide;

   // stage A: p = year - 1, floor(p / 100)
   assign p_in    = operand - 14'd1;
   assign q_prod  = 27'(p_in) * 27'(DIV100_MUL);
   assign qp_in   = 8'(q_prod >> DIV100_SHIFT);
   assign quad_in = (operand[1:0] == 2'b00);

   // stage B: year divisible by 100 exactly when p mod 100 is 99
   assign rem100   = p_ff - 14'(qp_ff * 14'd100);
   assign century  = (rem100 == 14'd99);
   assign leap_in  = quad_ff && (!century || (qp_ff[1:0] == 2'b11));
   assign dby_wide = 23'(p_ff) * 23'd365 + 23'(p_ff >> 2) - 23'(qp_ff) + 23'(qp_ff >> 2);
   assign dby_in   = dby_wide[21:0];

   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      qp_ff   <= qp_in;
      quad_ff <= quad_in;
      dby_ff  <= dby_in;
      leap_ff <= leap_in;
   end

   assign dby  = dby_ff;
   assign leap = leap_ff;

endmodule

FILE: rtl/core/cds_datapath.sv
// Datapath of the calendar date stepper: stored date, serial arithmetic,
// year search, month walk and result register. Depends on cds_pkg, cds_year_unit.
module cds_datapath import cds_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [39:0]   req_tdata,
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [47:0]   rsp_tdata,
   output logic          rsp_tuser,
   input  dp_cmd_type    cmd,
   output dp_status_type status
);

   func_type    func_ff, func_in;
   logic [4:0]  in_day_ff, in_day_in;
   logic [3:0]  in_month_ff, in_month_in;
   logic [13:0] in_year_ff, in_year_in;
   logic [15:0] in_count_ff, in_count_in;

   logic [4:0]  stored_day_ff, stored_day_in;
   logic [3:0]  stored_month_ff, stored_month_in;
   logic [13:0] stored_year_ff, stored_year_in;
   logic [21:0] cur_ff, cur_in;

   logic [13:0] y_ff, y_in;
   logic [3:0]  m_ff, m_in;
   logic [8:0]  rem_ff, rem_in;
   logic        leap_keep_ff, leap_keep_in;
   logic [21:0] g_ff, g_in;
   logic        valid_ff, valid_in;

   logic        res_err_ff, res_err_in;
   logic [21:0] res_diff_ff, res_diff_in;
   ord_type     res_ord_ff, res_ord_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic        rsp_user_ff, rsp_user_in;

   logic [13:0] yu_operand;
   logic [21:0] yu_dby;
   logic        yu_leap;
   logic [22:0] fwd_sum;
   logic [33:0] est_prod;
   logic [4:0]  dim_cur;

   always_comb begin
      unique case (cmd.yr_sel)
         YR_NEXT:  yu_operand = y_ff + 14'd1;
         YR_GIVEN: yu_operand = in_year_ff;
         default:  yu_operand = y_ff;
      endcase
   end

   cds_year_unit u_year (
      .clock   (clock),
      .operand (yu_operand),
      .dby     (yu_dby),
      .leap    (yu_leap)
   );

   assign fwd_sum  = {1'b0, cur_ff} + 23'(in_count_ff);
   assign est_prod = 34'(cur_ff) * 34'(DIV366_MUL);
   assign dim_cur  = days_in_month(m_ff, leap_keep_ff);

   always_comb begin
      func_in         = func_ff;
      in_day_in       = in_day_ff;
      in_month_in     = in_month_ff;
      in_year_in      = in_year_ff;
      in_count_in     = in_count_ff;
      stored_day_in   = stored_day_ff;
      stored_month_in = stored_month_ff;
      stored_year_in  = stored_year_ff;
      cur_in          = cur_ff;
      y_in            = y_ff;
      m_in            = m_ff;
      rem_in          = rem_ff;
      leap_keep_in    = leap_keep_ff;
      g_in            = g_ff;
      valid_in        = valid_ff;
      res_err_in      = res_err_ff;
      res_diff_in     = res_diff_ff;
      res_ord_in      = res_ord_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_user_in     = rsp_user_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;

      if (cmd.capture) begin
         func_in     = func_type'(req_tuser);
         in_day_in   = req_tdata[4:0];
         in_month_in = req_tdata[8:5];
         in_year_in  = req_tdata[22:9];
         in_count_in = req_tdata[38:23];
      end

      if (cmd.check) begin
         valid_in = (in_year_ff != 14'd0) && (in_year_ff <= MAX_YEAR) &&
                    (in_month_ff != 4'd0) && (in_month_ff <= 4'd12) &&
                    (in_day_ff != 5'd0) &&
                    (in_day_ff <= days_in_month(in_month_ff, yu_leap));
         g_in     = yu_dby + 22'(days_before_month(in_month_ff, yu_leap)) +
                    22'(in_day_ff) - 22'd1;
      end

      if (cmd.resolve) begin
         res_err_in  = !valid_ff;
         res_diff_in = '0;
         res_ord_in  = ORD_EQUAL;
         if (valid_ff) begin
            if (func_ff == FUNC_LOAD) begin
               stored_day_in   = in_day_ff;
               stored_month_in = in_month_ff;
               stored_year_in  = in_year_ff;
               cur_in          = g_ff;
            end else begin
               if (g_ff > cur_ff) begin
                  res_diff_in = g_ff - cur_ff;
                  res_ord_in  = ORD_EARLIER;
               end else if (cur_ff > g_ff) begin
                  res_diff_in = cur_ff - g_ff;
                  res_ord_in  = ORD_LATER;
               end
            end
         end
      end

      if (cmd.step_add) begin
         res_err_in  = 1'b0;
         res_diff_in = '0;
         res_ord_in  = ORD_EQUAL;
         if (func_ff == FUNC_FWD) begin
            if (fwd_sum > 23'(LAST_SERIAL)) begin
               cur_in     = LAST_SERIAL;
               res_err_in = 1'b1;
            end else begin
               cur_in = fwd_sum[21:0];
            end
         end else begin
            if (22'(in_count_ff) > cur_ff) begin
               cur_in     = '0;
               res_err_in = 1'b1;
            end else begin
               cur_in = cur_ff - 22'(in_count_ff);
            end
         end
      end

      if (cmd.estimate) begin
         y_in = 14'(est_prod >> DIV366_SHIFT) + 14'd1;
      end

      if (cmd.y_inc) begin
         y_in = y_ff + 14'd1;
      end

      if (cmd.base_sub) begin
         rem_in       = 9'(cur_ff - yu_dby);
         m_in         = 4'd1;
         leap_keep_in = yu_leap;
      end

      if (cmd.month_step) begin
         rem_in = rem_ff - 9'(dim_cur);
         m_in   = m_ff + 4'd1;
      end

      if (cmd.month_store) begin
         stored_day_in   = 5'(rem_ff) + 5'd1;
         stored_month_in = m_ff;
         stored_year_in  = y_ff;
      end

      if (cmd.out_write) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, res_ord_ff, res_diff_ff, stored_year_ff,
                         stored_month_ff, stored_day_ff};
         rsp_user_in  = res_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_day_ff   <= 5'd1;
         stored_month_ff <= 4'd1;
         stored_year_ff  <= 14'd2000;
         cur_ff          <= RESET_SERIAL;
         rsp_valid_ff    <= 1'b0;
      end else begin
         stored_day_ff   <= stored_day_in;
         stored_month_ff <= stored_month_in;
         stored_year_ff  <= stored_year_in;
         cur_ff          <= cur_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      in_day_ff    <= in_day_in;
      in_month_ff  <= in_month_in;
      in_year_ff   <= in_year_in;
      in_count_ff  <= in_count_in;
      y_ff         <= y_in;
      m_ff         <= m_in;
      rem_ff       <= rem_in;
      leap_keep_ff <= leap_keep_in;
      g_ff         <= g_in;
      valid_ff     <= valid_in;
      res_err_ff   <= res_err_in;
      res_diff_ff  <= res_diff_in;
      res_ord_ff   <= res_ord_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign status.func        = func_ff;
   assign status.year_at_max = (y_ff == MAX_YEAR);
   assign status.next_fits   = (yu_dby <= cur_ff);
   assign status.month_more  = (m_ff != 4'd12) && (rem_ff >= 9'(dim_cur));
   assign status.out_free    = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

FILE: rtl/core/cds_ctrl.sv
// Sequencer of the calendar date stepper: walks each request through the
// datapath by commands and status. Depends on cds_pkg.
module cds_ctrl import cds_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_GIVEN_A,
      ST_GIVEN_B,
      ST_CHECK,
      ST_RESOLVE,
      ST_STEP_ADD,
      ST_ESTIMATE,
      ST_SEARCH_A,
      ST_SEARCH_B,
      ST_SEARCH_CMP,
      ST_BASE_A,
      ST_BASE_B,
      ST_BASE_SUB,
      ST_MONTH,
      ST_OUTPUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.yr_sel = YR_CUR;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (status.func)
               FUNC_LOAD, FUNC_DIFF: state_in = ST_GIVEN_A;
               FUNC_FWD, FUNC_BACK:  state_in = ST_STEP_ADD;
            endcase
         end
         ST_GIVEN_A: begin
            cmd.yr_sel = YR_GIVEN;
            state_in   = ST_GIVEN_B;
         end
         ST_GIVEN_B: state_in = ST_CHECK;
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_RESOLVE;
         end
         ST_RESOLVE: begin
            cmd.resolve = 1'b1;
            state_in    = ST_OUTPUT;
         end
         ST_STEP_ADD: begin
            cmd.step_add = 1'b1;
            state_in     = ST_ESTIMATE;
         end
         ST_ESTIMATE: begin
            cmd.estimate = 1'b1;
            state_in     = ST_SEARCH_A;
         end
         ST_SEARCH_A: begin
            cmd.yr_sel = YR_NEXT;
            state_in   = status.year_at_max ? ST_BASE_A : ST_SEARCH_B;
         end
         ST_SEARCH_B: state_in = ST_SEARCH_CMP;
         ST_SEARCH_CMP: begin
            if (status.next_fits) begin
               cmd.y_inc = 1'b1;
               state_in  = ST_SEARCH_A;
            end else begin
               state_in = ST_BASE_A;
            end
         end
         ST_BASE_A: state_in = ST_BASE_B;
         ST_BASE_B: state_in = ST_BASE_SUB;
         ST_BASE_SUB: begin
            cmd.base_sub = 1'b1;
            state_in     = ST_MONTH;
         end
         ST_MONTH: begin
            if (status.month_more) begin
               cmd.month_step = 1'b1;
            end else begin
               cmd.month_store = 1'b1;
               state_in        = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (status.out_free) begin
               cmd.out_write = 1'b1;
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

FILE: rtl/core/cds_checker.sv
// Port-level assertions for the calendar date stepper, bound to the top level.
// Depends only on the ports of calendar_date_stepper.
module cds_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [39:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // reset empties the response register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // one request at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // an error response carries no difference and no order
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[46:23] == 24'd0)
      else $error("error response with difference or order");

   // order says equal exactly when the difference is zero
   a_order_diff: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[46:45] == 2'd0) == (rsp_tdata[44:23] == 22'd0)))
      else $error("order disagrees with day difference");

endmodule

bind calendar_date_stepper cds_checker u_cds_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: tb/tb_calendar_date_stepper.sv
// Self-checking testbench for calendar_date_stepper: a date ledger class predicts every response.
// Requests go in on the req_ stream and responses come back on the rsp_ stream.
// Depends on cds_pkg and the calendar_date_stepper RTL.

typedef struct packed {
   logic [4:0]       day;
   logic [3:0]       month;
   logic [13:0]      year;
   logic             err;
   logic [21:0]      diff;
   cds_pkg::ord_type order;
} date_result_type;

class date_ledger;
   logic [4:0]      held_day;
   logic [3:0]      held_month;
   logic [13:0]     held_year;
   date_result_type pending_dates[$];
   int              mismatches;

   function new();
      held_day   = 5'd1;
      held_month = 4'd1;
      held_year  = 14'd2000;
      mismatches = 0;
   endfunction

   static function bit is_leap(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   static function int unsigned month_days(int unsigned m, int unsigned y);
      case (m)
         2:           return is_leap(y) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   static function bit date_ok(int unsigned d, int unsigned m, int unsigned y);
      if (y < 1 || y > 9999 || m < 1 || m > 12 || d < 1) begin
         return 1'b0;
      end
      return d <= month_days(m, y);
   endfunction

   // days from 0001-01-01 to January 1 of year y
   static function int unsigned year_base(int unsigned y);
      int unsigned p;
      p = y - 1;
      return p * 365 + p / 4 - p / 100 + p / 400;
   endfunction

   static function int unsigned to_serial(int unsigned d, int unsigned m, int unsigned y);
      int unsigned s;
      s = year_base(y);
      for (int unsigned i = 1; i < m; i++) begin
         s += month_days(i, y);
      end
      return s + d - 1;
   endfunction

   function void place_serial(int unsigned s);
      int unsigned y;
      int unsigned m;
      int unsigned r;
      y = s / 366 + 1;
      m = 1;
      while (y < 9999 && year_base(y + 1) <= s) begin
         y++;
      end
      r = s - year_base(y);
      while (m < 12 && r >= month_days(m, y)) begin
         r -= month_days(m, y);
         m++;
      end
      held_day   = 5'(r + 1);
      held_month = 4'(m);
      held_year  = 14'(y);
   endfunction

   task report(string msg);
      if (mismatches < 40) begin
         $display("ERROR: %s", msg);
      end
      mismatches++;
   endtask

   // apply one accepted request to the held date and queue its response
   function void note_request(cds_pkg::func_type f, logic [4:0] d, logic [3:0] m,
                              logic [13:0] y, logic [15:0] n);
      date_result_type res;
      int unsigned     here;
      int unsigned     there;
      int unsigned     target;
      res  = '0;
      here = to_serial(held_day, held_month, held_year);
      case (f)
         cds_pkg::FUNC_LOAD: begin
            if (date_ok(d, m, y)) begin
               held_day   = d;
               held_month = m;
               held_year  = y;
            end else begin
               res.err = 1'b1;
            end
         end
         cds_pkg::FUNC_FWD: begin
            target = here + n;
            if (target > cds_pkg::LAST_SERIAL) begin
               target  = cds_pkg::LAST_SERIAL;
               res.err = 1'b1;
            end
            place_serial(target);
         end
         cds_pkg::FUNC_BACK: begin
            if (n > here) begin
               target  = 0;
               res.err = 1'b1;
            end else begin
               target = here - n;
            end
            place_serial(target);
         end
         default: begin
            if (date_ok(d, m, y)) begin
               there = to_serial(d, m, y);
               if (here < there) begin
                  res.diff  = 22'(there - here);
                  res.order = cds_pkg::ORD_EARLIER;
               end else if (here > there) begin
                  res.diff  = 22'(here - there);
                  res.order = cds_pkg::ORD_LATER;
               end
            end else begin
               res.err = 1'b1;
            end
         end
      endcase
      res.day   = held_day;
      res.month = held_month;
      res.year  = held_year;
      pending_dates.push_back(res);
   endfunction

   task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         report($sformatf("%s: got %0d, expected %0d", name, got, want));
      end
   endtask

   task check_response(logic [47:0] data, logic err_bit);
      date_result_type want;
      if (pending_dates.size() == 0) begin
         report("response with no request outstanding");
         return;
      end
      want = pending_dates.pop_front();
      compare_field("day_out", data[4:0], want.day);
      compare_field("month_out", data[8:5], want.month);
      compare_field("year_out", data[22:9], want.year);
      compare_field("error_flag", err_bit, want.err);
      compare_field("day_difference", data[44:23], want.diff);
      compare_field("order", data[46:45], want.order);
   endtask

   function int pending_count();
      return pending_dates.size();
   endfunction
endclass

module tb_calendar_date_stepper;
   timeunit 1ns;
   timeprecision 1ps;
   import cds_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int          HOLD_CYCLES  = 600;   // long receiver hold-off
   localparam int          DRAIN_CYCLES = 200;   // well past the slowest step

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // day_in, month_in, year_in, step_count, pad (low bit up)
   logic [1:0]  req_tuser  = '0;   // func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // day_out, month_out, year_out, day_difference, order, pad
   logic        rsp_tuser;         // error_flag

   date_ledger  ledger = new();

   // sender idle and receiver stall chances, in percent
   int          tx_idle_pct  = 0;
   int          rx_stall_pct = 0;
   // bump hold_seq to ask the receiver for one long hold-off
   int          hold_seq     = 0;
   int          hold_seen    = 0;
   int          hold_left    = 0;
   int unsigned cycle_count  = 0;

   calendar_date_stepper dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Receiver: stall at random, or hold off completely for a long stretch on request
   // so that the block fills up and drops req_tready while the sender keeps offering.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_seq != hold_seen) begin
         hold_seen  <= hold_seq;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
   end

   // Check every accepted response against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         ledger.check_response(rsp_tdata, rsp_tuser);
      end
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("calendar_date_stepper: mismatch");
         $finish;
      end
   end

   // Offer one request, idling first at random, and hold it until accepted.
   // Keep req_tvalid high across back-to-back requests; only lower it for idle cycles.
   task automatic send_request(func_type f, logic [4:0] d, logic [3:0] m,
                               logic [13:0] y, logic [15:0] n);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {1'b0, n, y, m, d};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      ledger.note_request(f, d, m, y, n);
   endtask

   // Pick a valid date, biased toward the range ends, century years and month ends.
   function automatic void pick_date(output logic [4:0] d, output logic [3:0] m,
                                     output logic [13:0] y);
      int unsigned yy;
      int unsigned mm;
      int unsigned len;
      case ($urandom_range(0, 9))
         0:       yy = $urandom_range(1, 3);
         1:       yy = $urandom_range(9997, 9999);
         2:       yy = 100 * $urandom_range(16, 25);
         3:       yy = 4 * $urandom_range(1, 2499);
         default: yy = $urandom_range(1, 9999);
      endcase
      mm  = $urandom_range(1, 12);
      len = ledger.month_days(mm, yy);
      d   = 5'(($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len));
      m   = 4'(mm);
      y   = 14'(yy);
   endfunction

   function automatic logic [15:0] pick_count();
      case ($urandom_range(0, 5))
         0:       return 16'($urandom_range(0, 3));
         1:       return 16'($urandom_range(0, 400));
         2:       return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // One random request: mostly valid loads, steps and compares, the rest raw field noise.
   task automatic send_random_request();
      logic [4:0]  d;
      logic [3:0]  m;
      logic [13:0] y;
      logic [15:0] n;
      int unsigned pick;
      d    = 5'($urandom_range(0, 31));
      m    = 4'($urandom_range(0, 15));
      y    = 14'($urandom_range(0, 16383));
      n    = 16'($urandom_range(0, 65535));
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
         pick_date(d, m, y);
         send_request(FUNC_LOAD, d, m, y, n);
      end else if (pick < 27) begin
         send_request(FUNC_LOAD, d, m, y, n);
      end else if (pick < 47) begin
         send_request(FUNC_FWD, d, m, y, pick_count());
      end else if (pick < 67) begin
         send_request(FUNC_BACK, d, m, y, pick_count());
      end else if (pick < 90) begin
         if ($urandom_range(0, 7) == 0) begin
            // compare against the held date itself
            d = ledger.held_day;
            m = ledger.held_month;
            y = ledger.held_year;
         end else begin
            pick_date(d, m, y);
         end
         send_request(FUNC_DIFF, d, m, y, n);
      end else begin
         send_request(FUNC_DIFF, d, m, y, n);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset date, range limits, leap rules, invalid fields, exact landings
      send_request(FUNC_DIFF, 5'd1, 4'd1, 14'd2000, 16'd0);      // equal to reset date
      send_request(FUNC_LOAD, 5'd1, 4'd1, 14'd1, 16'd0);         // lowest date
      send_request(FUNC_BACK, 5'd0, 4'd0, 14'd0, 16'd1);         // saturate low
      send_request(FUNC_FWD, 5'd0, 4'd0, 14'd0, 16'd0);          // zero step
      send_request(FUNC_FWD, 5'd31, 4'd15, 14'h3FFF, 16'hFFFF);  // largest step
      send_request(FUNC_BACK, 5'd31, 4'd15, 14'h3FFF, 16'hFFFF); // land exactly on low limit
      send_request(FUNC_LOAD, 5'd31, 4'd12, 14'd9999, 16'd0);    // highest date
      send_request(FUNC_FWD, 5'd0, 4'd0, 14'd0, 16'd1);          // saturate high
      send_request(FUNC_DIFF, 5'd1, 4'd1, 14'd1, 16'd0);         // widest difference
      send_request(FUNC_LOAD, 5'd1, 4'd12, 14'd9999, 16'd0);
      send_request(FUNC_FWD, 5'd0, 4'd0, 14'd0, 16'd30);         // land exactly on high limit
      send_request(FUNC_BACK, 5'd0, 4'd0, 14'd0, 16'hFFFF);
      send_request(FUNC_LOAD, 5'd29, 4'd2, 14'd2000, 16'd0);     // leap by the 400 rule
      send_request(FUNC_LOAD, 5'd29, 4'd2, 14'd1900, 16'd0);     // not leap by the 100 rule
      send_request(FUNC_LOAD, 5'd29, 4'd2, 14'd2004, 16'd0);     // plain leap year
      send_request(FUNC_LOAD, 5'd31, 4'd4, 14'd2023, 16'd0);     // day past month end
      send_request(FUNC_LOAD, 5'd0, 4'd1, 14'd2023, 16'd0);      // day zero
      send_request(FUNC_LOAD, 5'd1, 4'd0, 14'd2023, 16'd0);      // month zero
      send_request(FUNC_LOAD, 5'd1, 4'd13, 14'd2023, 16'd0);     // month past December
      send_request(FUNC_LOAD, 5'd1, 4'd1, 14'd0, 16'd0);         // year zero
      send_request(FUNC_LOAD, 5'd1, 4'd1, 14'd10000, 16'd0);     // year past range
      send_request(FUNC_LOAD, 5'd31, 4'd15, 14'h3FFF, 16'd0);    // all field bits set
      send_request(FUNC_DIFF, 5'd30, 4'd2, 14'd2000, 16'd0);     // invalid compare date
      send_request(FUNC_DIFF, 5'd31, 4'd12, 14'd1999, 16'd0);    // held date is later
      send_request(FUNC_LOAD, 5'd31, 4'd12, 14'd1999, 16'd0);
      send_request(FUNC_FWD, 5'd0, 4'd0, 14'd0, 16'd1);          // roll over the year end

      // random phases: no idling (with one long hold-off), sender idle, receiver stall, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct  = 0;
               rx_stall_pct <= 0;
               hold_seq     <= hold_seq + 1;
            end
            1: begin
               tx_idle_pct  = 85;
               rx_stall_pct <= 0;
            end
            2: begin
               tx_idle_pct  = 0;
               rx_stall_pct <= 85;
            end
            default: begin
               tx_idle_pct  = 24;
               rx_stall_pct <= 24;
            end
         endcase
         repeat ((phase == 0) ? 300 : 290) send_random_request();
      end
      req_tvalid <= 1'b0;

      // drain: wait for every predicted response, then watch for strays
      while (ledger.pending_count() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (ledger.mismatches == 0) begin
         $display("calendar_date_stepper: match");
      end else begin
         $display("calendar_date_stepper: mismatch");
      end
      $finish;
   end

endmodule
